// File: sv/sist_pkg.sv
// shared types and constants for the sorted integer set table
// no dependencies; imported by every module of the block
package sist_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STAT_W   = 2;
   localparam int POS_W    = 6;
   localparam int TOTAL_W  = 7;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT     = 3'd0,
      KIND_FIND       = 3'd1,
      KIND_REMOVE_VAL = 3'd2,
      KIND_REMOVE_IDX = 3'd3,
      KIND_READ_IDX   = 3'd4,
      KIND_CLEAR      = 3'd5
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_MISS    = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_RANGE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PROBE,
      ST_EXEC,
      ST_SHIFT,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] entry_total;
      logic [DATA_W-1:0]  read_value;
      logic [POS_W-1:0]   position;
      logic [STAT_W-1:0]  status;
   } result_type;

endpackage

// File: sv/sist_mem.sv
// entry store: one write port, one registered read port
// depends on sist_pkg
module sist_mem (
   input  logic                        clock,
   input  sist_pkg::mem_wr_type        wr,
   input  logic [sist_pkg::ADDR_W-1:0] rd_addr,
   output logic [sist_pkg::DATA_W-1:0] rd_data
);
   import sist_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sist_seq.sv
// sequencer: binary search over the store and one-entry-a-cycle shifting
// depends on sist_pkg and drives sist_mem
module sist_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sist_pkg::KIND_W-1:0] kind,
   input  logic [sist_pkg::DATA_W-1:0] value,
   input  logic [sist_pkg::POS_W-1:0]  index,
   output logic                        idle,
   output logic                        done,
   input  logic                        ack,
   output sist_pkg::result_type        result,
   output sist_pkg::mem_wr_type        wr,
   output logic [sist_pkg::ADDR_W-1:0] rd_addr,
   input  logic [sist_pkg::DATA_W-1:0] rd_data
);
   import sist_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pend_ff, pend_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_W-1:0]   mid_ff, mid_in;
   logic [CNT_W-1:0]    slot_ff, slot_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [ADDR_W-1:0]   tgt_ff, tgt_in;
   logic                up_ff, up_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   rval_ff, rval_in;

   logic [CNT_W:0]      mid_sum;
   logic [CNT_W-1:0]    ptr_dn, ptr_up, mid_next;
   logic                more;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign ptr_dn   = ptr_ff - CNT_W'(1);
   assign ptr_up   = ptr_ff + CNT_W'(1);
   assign mid_next = CNT_W'(mid_ff) + CNT_W'(1);
   assign more     = up_ff ? (ptr_ff > slot_ff) : (ptr_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      slot_ff   <= slot_in;
      found_ff  <= found_in;
      ptr_ff    <= ptr_in;
      tgt_ff    <= tgt_in;
      up_ff     <= up_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      rval_ff   <= rval_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      slot_in   = slot_ff;
      found_in  = found_ff;
      ptr_in    = ptr_ff;
      tgt_in    = tgt_ff;
      up_in     = up_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      rval_in   = rval_ff;
      wr        = '0;
      rd_addr   = mid_sum[ADDR_W:1];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in   = kind;
               value_in  = value;
               idx_in    = ADDR_W'(index);
               lo_in     = '0;
               hi_in     = count_ff;
               found_in  = 1'b0;
               pend_in   = 1'b0;
               status_in = STAT_OK;
               pos_in    = '0;
               rval_in   = '0;
               case (kind)
                  KIND_INSERT, KIND_FIND, KIND_REMOVE_VAL: begin
                     state_in = ST_SEARCH;
                  end
                  KIND_REMOVE_IDX: begin
                     if (CNT_W'(index) < count_ff) begin
                        count_in = count_ff - CNT_W'(1);
                        ptr_in   = CNT_W'(index);
                        up_in    = 1'b0;
                        pos_in   = index;
                        state_in = ST_SHIFT;
                     end else begin
                        status_in = STAT_RANGE;
                        state_in  = ST_DONE;
                     end
                  end
                  KIND_READ_IDX: begin
                     if (CNT_W'(index) < count_ff) begin
                        pos_in   = index;
                        state_in = ST_RD_ADDR;
                     end else begin
                        status_in = STAT_RANGE;
                        state_in  = ST_DONE;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[ADDR_W:1];
               state_in = ST_PROBE;
            end else begin
               slot_in  = lo_ff;
               state_in = ST_EXEC;
            end
         end
         ST_PROBE: begin
            if ($signed(rd_data) == value_ff) begin
               found_in = 1'b1;
               slot_in  = CNT_W'(mid_ff);
               state_in = ST_EXEC;
            end else if ($signed(rd_data) < value_ff) begin
               lo_in    = mid_next;
               state_in = ST_SEARCH;
            end else begin
               hi_in    = CNT_W'(mid_ff);
               state_in = ST_SEARCH;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (kind_ff)
               KIND_INSERT: begin
                  if (found_ff) begin
                     status_in = STAT_MISS;
                     pos_in    = slot_ff[POS_W-1:0];
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                  end else begin
                     ptr_in   = count_ff;
                     up_in    = 1'b1;
                     pos_in   = slot_ff[POS_W-1:0];
                     state_in = ST_SHIFT;
                  end
               end
               KIND_FIND: begin
                  if (found_ff) begin
                     pos_in = slot_ff[POS_W-1:0];
                  end else begin
                     status_in = STAT_MISS;
                  end
               end
               KIND_REMOVE_VAL: begin
                  if (found_ff) begin
                     count_in = count_ff - CNT_W'(1);
                     ptr_in   = slot_ff;
                     up_in    = 1'b0;
                     pos_in   = slot_ff[POS_W-1:0];
                     state_in = ST_SHIFT;
                  end else begin
                     status_in = STAT_MISS;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end
         ST_SHIFT: begin
            wr.en   = pend_ff;
            wr.addr = tgt_ff;
            wr.data = rd_data;
            rd_addr = up_ff ? ptr_dn[ADDR_W-1:0] : ptr_up[ADDR_W-1:0];
            if (more) begin
               pend_in = 1'b1;
               tgt_in  = ptr_ff[ADDR_W-1:0];
               ptr_in  = up_ff ? ptr_dn : ptr_up;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (up_ff) begin
                     wr.en    = 1'b1;
                     wr.addr  = slot_ff[ADDR_W-1:0];
                     wr.data  = value_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_RD_ADDR: begin
            rd_addr  = idx_ff;
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            rval_in  = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle               = (state_ff == ST_IDLE);
   assign done               = (state_ff == ST_DONE);
   assign result.status      = status_ff;
   assign result.position    = pos_ff;
   assign result.read_value  = rval_ff;
   assign result.entry_total = TOTAL_W'(count_ff);

endmodule

// File: sv/sorted_integer_set_table.sv
// top level of the sorted integer set table: stream ports and result register
// depends on sist_pkg, sist_seq and sist_mem
//
// Holds up to 64 distinct signed 32-bit integers in ascending order in a
// single-port-write, registered-read store, driven by one sequencer that uses
// the store's read port for everything. Each request word gives exactly one
// response word. Find, insert and remove by value run a binary search of at
// most 7 probes; insert and both removes move up to 63 entries through
// the store, one entry per cycle, and this shift sets the worst case. Read at
// index does one store read; clear, an index out of range and the unused kinds
// go straight to the result.
// A new request is taken once the previous result has moved into the output
// register, while that result may still wait for rsp_tready.
module sorted_integer_set_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // kind[2:0], value[34:3], index[40:35], zero pad
   input  logic [sist_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[1:0], position[7:2], read_value[39:8], entry_total[46:40], zero pad
   output logic [sist_pkg::RSP_W-1:0] rsp_tdata
);
   import sist_pkg::*;

   logic              idle, done, load;
   result_type        result;
   mem_wr_type        wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   assign req_tready = idle;
   assign load       = done && (!rsp_valid_ff || rsp_tready);

   sist_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (req_tvalid && idle),
      .kind    (req_tdata[2:0]),
      .value   (req_tdata[34:3]),
      .index   (req_tdata[40:35]),
      .idle    (idle),
      .done    (done),
      .ack     (load),
      .result  (result),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sist_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - $bits(result_type))'(0), rsp_data_ff};

endmodule
